// ===== hw/rtl/twcht_pkg.sv =====
package twcht_pkg;

  localparam int unsigned CODE_W    = 8;
  localparam int unsigned FIRST_W   = 7;
  localparam int unsigned NUM_W     = 8;
  localparam int unsigned ADV_W     = 12;
  localparam int unsigned GIDX_W    = 7;
  localparam int unsigned TX_W      = 27;
  localparam int unsigned TY_W      = 16;
  localparam int unsigned WIDTH_W   = 26;
  localparam int unsigned COUNT_W   = 13;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 27;

  localparam logic [WIDTH_W-1:0] WIDTH_MAX = '1;

  localparam logic FUNC_MEASURE = 1'b0;
  localparam logic FUNC_LOAD    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CHAR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHARS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Y    = 3'd4;

  localparam logic [FIRST_W-1:0] FIRST_CHAR_RST  = 7'd32;
  localparam logic [NUM_W-1:0]   NUM_CHARS_RST   = 8'd96;
  localparam logic [ADV_W-1:0]   LINE_HEIGHT_RST = 12'd256;

  localparam logic [CODE_W-1:0] CHAR_TAB       = 8'h09;
  localparam logic [CODE_W-1:0] CHAR_CR        = 8'h0D;
  localparam logic [CODE_W-1:0] CHAR_SPACE     = 8'h20;
  localparam logic [CODE_W-1:0] CHAR_SILENT_LO = 8'h01;
  localparam logic [CODE_W-1:0] CHAR_SILENT_HI = 8'h05;
  localparam logic [CODE_W-1:0] CHAR_FALLBACK  = 8'd127;

  localparam int unsigned TAB_SHIFT     = 2;
  localparam int unsigned BELOW_MARGIN  = 5;

  typedef enum logic [1:0] {
    KIND_GLYPH,
    KIND_TAB,
    KIND_SILENT
  } kind_e;

  typedef struct packed {
    logic              func;
    logic [CODE_W-1:0] char_code;
    logic              is_last;
    logic [GIDX_W-1:0] glyph_index;
    logic [ADV_W-1:0]  advance;
  } in_req_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] total_width;
    logic [COUNT_W-1:0] char_count;
    logic [COUNT_W-1:0] caret_index;
  } out_res_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    kind_e            kind;
    logic [ADV_W-1:0] adv;
  } stage_t;

endpackage

// ===== hw/rtl/text_width_and_caret_hit_test.sv =====
// text width and caret hit test
//
// load the glyph advance table with func = load requests (glyph_index,
// advance), then send the characters of a string as func = measure
// requests, is_last set on the final one. the last character yields one
// result: total width, character count and the caret index nearest
// target_x (or the length when target_y lies below the line).
// registers first_char, num_chars, line_height, target_x, target_y are
// written through cfg_we_i / cfg_index_i / cfg_wdata_i; the user must write
// them only while idle, as the block itself does not enforce it.
// one request per cycle is accepted while in_stall_o is low. a last
// character's glyph table read is registered in the lookup stage, then its
// width sum and caret compare in the output register behind out_valid_o.
// when out_stall_i holds a result, the block keeps taking characters and
// only stalls the input once a further last character is waiting.
// reset clears the string sums and the valid flags and restores the
// register defaults; the glyph table holds no value until loaded.
module text_width_and_caret_hit_test #(
  parameter int unsigned GLYPH_SLOTS = 128,
  parameter int unsigned MAX_STRING  = 4096,
  parameter int unsigned FRAC_BITS   = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [twcht_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [twcht_pkg::CFG_DAT_W-1:0]   cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  twcht_pkg::in_req_t                in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output twcht_pkg::out_res_t               out_res_o
);

  logic [twcht_pkg::FIRST_W-1:0] first_char_q;
  logic [twcht_pkg::NUM_W-1:0]   num_chars_q;
  logic [twcht_pkg::ADV_W-1:0]   line_height_q;
  logic [twcht_pkg::TX_W-1:0]    target_x_q;
  logic [twcht_pkg::TY_W-1:0]    target_y_q;

  twcht_pkg::stage_t   stage;
  twcht_pkg::out_res_t res;
  twcht_pkg::out_res_t res_q;
  logic                out_valid_q;
  logic                accept;
  logic                fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_char_q  <= twcht_pkg::FIRST_CHAR_RST;
      num_chars_q   <= twcht_pkg::NUM_CHARS_RST;
      line_height_q <= twcht_pkg::LINE_HEIGHT_RST;
      target_x_q    <= '0;
      target_y_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        twcht_pkg::CFG_FIRST_CHAR:  first_char_q  <= cfg_wdata_i[twcht_pkg::FIRST_W-1:0];
        twcht_pkg::CFG_NUM_CHARS:   num_chars_q   <= cfg_wdata_i[twcht_pkg::NUM_W-1:0];
        twcht_pkg::CFG_LINE_HEIGHT: line_height_q <= cfg_wdata_i[twcht_pkg::ADV_W-1:0];
        twcht_pkg::CFG_TARGET_X:    target_x_q    <= cfg_wdata_i[twcht_pkg::TX_W-1:0];
        twcht_pkg::CFG_TARGET_Y:    target_y_q    <= cfg_wdata_i[twcht_pkg::TY_W-1:0];
        default: ;
      endcase
    end
  end

  // a last character may only move on when the output register frees up
  assign fire       = stage.valid && (!stage.last || !out_valid_q || !out_stall_i);
  assign in_stall_o = stage.valid && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  twcht_glyph_lookup #(
    .GLYPH_SLOTS (GLYPH_SLOTS)
  ) u_lookup (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .req_i        (in_req_i),
    .first_char_i (first_char_q),
    .num_chars_i  (num_chars_q),
    .fire_i       (fire),
    .stage_o      (stage)
  );

  twcht_accum #(
    .MAX_STRING (MAX_STRING),
    .FRAC_BITS  (FRAC_BITS)
  ) u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_i       (stage),
    .fire_i        (fire),
    .line_height_i (line_height_q),
    .target_x_i    (target_x_q),
    .target_y_i    (target_y_q),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && stage.last) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && stage.last) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

`ifndef ASSERT_OFF
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (stage.valid && stage.last && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked last character");
`endif

endmodule

// ===== hw/rtl/twcht_glyph_lookup.sv =====
module twcht_glyph_lookup #(
  parameter int unsigned GLYPH_SLOTS = 128
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  twcht_pkg::in_req_t              req_i,
  input  logic [twcht_pkg::FIRST_W-1:0]   first_char_i,
  input  logic [twcht_pkg::NUM_W-1:0]     num_chars_i,
  input  logic                            fire_i,
  output twcht_pkg::stage_t               stage_o
);

  localparam int unsigned IDX_W = $clog2(GLYPH_SLOTS);

  logic [twcht_pkg::ADV_W-1:0] mem [GLYPH_SLOTS];

  logic [twcht_pkg::CODE_W-1:0] sel_code;
  logic [twcht_pkg::CODE_W-1:0] diff;
  logic [twcht_pkg::CODE_W-1:0] fc_ext;
  logic [twcht_pkg::CODE_W-1:0] raw_idx;
  logic                         in_range;
  logic [IDX_W-1:0]             rd_idx;
  logic                         is_tab;
  logic                         is_silent;
  twcht_pkg::kind_e             kind_d;
  logic                         meas;
  logic                         load_wr;

  logic                         valid_q;
  logic                         last_q;
  twcht_pkg::kind_e             kind_q;
  logic [twcht_pkg::ADV_W-1:0]  adv_q;

  // fold an entry number into the table, one conditional subtract per step
  function automatic logic [IDX_W-1:0] slot_of(input logic [twcht_pkg::CODE_W-1:0] raw);
    int v;
    v = int'(raw);
    for (int k = 6; k >= 0; k--) begin
      if (v >= (GLYPH_SLOTS << k)) begin
        v = v - (GLYPH_SLOTS << k);
      end
    end
    return IDX_W'(v);
  endfunction

  always_comb begin
    is_tab    = (req_i.char_code == twcht_pkg::CHAR_TAB);
    is_silent = (req_i.char_code == twcht_pkg::CHAR_CR) ||
                ((req_i.char_code >= twcht_pkg::CHAR_SILENT_LO) &&
                 (req_i.char_code <= twcht_pkg::CHAR_SILENT_HI));
    sel_code  = is_tab ? twcht_pkg::CHAR_SPACE : req_i.char_code;
    fc_ext    = {1'b0, first_char_i};
    diff      = sel_code - fc_ext;
    in_range  = !sel_code[twcht_pkg::CODE_W-1] && (sel_code >= fc_ext) &&
                (diff < num_chars_i);
    // out of range codes take the fallback glyph
    raw_idx   = in_range ? diff : (twcht_pkg::CHAR_FALLBACK - fc_ext);
    rd_idx    = slot_of(raw_idx);
    if (is_tab) begin
      kind_d = twcht_pkg::KIND_TAB;
    end else if (is_silent) begin
      kind_d = twcht_pkg::KIND_SILENT;
    end else begin
      kind_d = twcht_pkg::KIND_GLYPH;
    end
    meas    = accept_i && (req_i.func == twcht_pkg::FUNC_MEASURE);
    load_wr = accept_i && (req_i.func == twcht_pkg::FUNC_LOAD) &&
              ({2'b00, req_i.glyph_index} < 9'(GLYPH_SLOTS));
  end

  always_ff @(posedge clk_i) begin
    if (load_wr) begin
      mem[IDX_W'(req_i.glyph_index)] <= req_i.advance;
    end
    if (meas) begin
      adv_q  <= mem[rd_idx];
      last_q <= req_i.is_last;
      kind_q <= kind_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept_i) begin
      valid_q <= meas;
    end else if (fire_i) begin
      valid_q <= 1'b0;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.last  = last_q;
  assign stage_o.kind  = kind_q;
  assign stage_o.adv   = adv_q;

endmodule

// ===== hw/rtl/twcht_accum.sv =====
module twcht_accum #(
  parameter int unsigned MAX_STRING = 4096,
  parameter int unsigned FRAC_BITS  = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  twcht_pkg::stage_t             stage_i,
  input  logic                          fire_i,
  input  logic [twcht_pkg::ADV_W-1:0]   line_height_i,
  input  logic [twcht_pkg::TX_W-1:0]    target_x_i,
  input  logic [twcht_pkg::TY_W-1:0]    target_y_i,
  output twcht_pkg::out_res_t           res_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_STRING + 1);
  localparam int unsigned MARGIN = twcht_pkg::BELOW_MARGIN << FRAC_BITS;
  localparam int unsigned ADD_W  = twcht_pkg::ADV_W + twcht_pkg::TAB_SHIFT;
  localparam int unsigned W      = twcht_pkg::WIDTH_W;

  logic [W-1:0]     run_q, run_d, prev_q, prev_d;
  logic [CNT_W-1:0] count_q, count_d, held_q, held_d;
  logic             found_q, found_d;

  logic [ADD_W-1:0] add_w;
  logic             take;
  logic [W:0]       sum;
  logic [W-1:0]     run_n;
  logic [W-1:0]     p_w, r_w;
  logic [CNT_W-1:0] cn, cand, caret_end, caret_fin;
  logic [W+2:0]     tx2, pr;
  logic             near;
  logic             beyond;
  logic             found_set;
  logic [17:0]      ty_ext, lim;
  logic             below;

  always_comb begin
    case (stage_i.kind)
      twcht_pkg::KIND_GLYPH:  add_w = ADD_W'(stage_i.adv);
      twcht_pkg::KIND_TAB:    add_w = {stage_i.adv, {twcht_pkg::TAB_SHIFT{1'b0}}};
      twcht_pkg::KIND_SILENT: add_w = '0;
      default:                add_w = ADD_W'(stage_i.adv);
    endcase

    take  = (count_q < CNT_W'(MAX_STRING));
    sum   = {1'b0, run_q} + (W + 1)'(add_w);
    run_n = sum[W] ? twcht_pkg::WIDTH_MAX : sum[W-1:0];

    // characters past the length limit leave the sums alone
    p_w = take ? run_q : prev_q;
    r_w = take ? run_n : run_q;
    cn  = take ? count_q + CNT_W'(1) : count_q;

    // strictly nearer to the left edge when 2x < left + right and the edges differ
    tx2    = {target_x_i[twcht_pkg::TX_W-1], target_x_i, 1'b0};
    pr     = {3'b000, p_w} + {3'b000, r_w};
    near   = (p_w != r_w) && ($signed(tx2) < $signed(pr));
    beyond = $signed({2'b00, r_w}) > $signed({target_x_i[twcht_pkg::TX_W-1], target_x_i});
    cand   = near ? cn - CNT_W'(1) : cn;

    found_set = take && !found_q && (beyond || stage_i.last);
    caret_end = found_q ? held_q : cand;

    ty_ext    = {{2{target_y_i[twcht_pkg::TY_W-1]}}, target_y_i};
    lim       = {6'b0, line_height_i} + 18'(MARGIN);
    below     = $signed(ty_ext) > $signed(lim);
    caret_fin = below ? cn : caret_end;

    run_d   = run_q;
    prev_d  = prev_q;
    count_d = count_q;
    found_d = found_q;
    held_d  = held_q;
    if (fire_i) begin
      if (stage_i.last) begin
        run_d   = '0;
        prev_d  = '0;
        count_d = '0;
        found_d = 1'b0;
        held_d  = '0;
      end else begin
        if (take) begin
          prev_d  = run_q;
          run_d   = run_n;
          count_d = cn;
        end
        if (found_set) begin
          found_d = 1'b1;
          held_d  = cand;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= '0;
      prev_q  <= '0;
      count_q <= '0;
      found_q <= 1'b0;
      held_q  <= '0;
    end else begin
      run_q   <= run_d;
      prev_q  <= prev_d;
      count_q <= count_d;
      found_q <= found_d;
      held_q  <= held_d;
    end
  end

  assign res_o.total_width = r_w;
  assign res_o.char_count  = twcht_pkg::COUNT_W'(cn);
  assign res_o.caret_index = twcht_pkg::COUNT_W'(caret_fin);

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_STRING))
    else $error("position count beyond string limit");

  a_width_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prev_q <= run_q)
    else $error("previous width above running width");

  a_caret_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (held_q <= count_q))
    else $error("held caret beyond position count");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && stage_i.last) |=> (count_q == '0) && !found_q && (run_q == '0))
    else $error("string state not cleared after last character");
`endif

endmodule

// ===== tb/text_width_checker.sv =====
module text_width_checker
  import twcht_pkg::*;
#(
  parameter int unsigned GLYPH_SLOTS = 128,
  parameter int unsigned MAX_STRING  = 4096,
  parameter int unsigned FRAC_BITS   = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  in_req_t              in_req_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  out_res_t             out_res_i,
  output int unsigned          mismatches_o,
  output int unsigned          results_due_o
);

  logic [FIRST_W-1:0] first_char;
  logic [NUM_W-1:0]   num_chars;
  logic [ADV_W-1:0]   line_height;
  longint             target_x;
  longint             target_y;

  logic [ADV_W-1:0]   glyph_adv [GLYPH_SLOTS];
  longint             run_width;
  longint             prev_width;
  int unsigned        char_pos;
  bit                 caret_set;
  int unsigned        caret_at;

  out_res_t           results_due [$];
  int unsigned        mismatches;

  function automatic longint advance_of(logic [CODE_W-1:0] code);
    int c;
    int f;
    int slot;
    c = code;
    f = first_char;
    if (c < 128 && c >= f && c - f < int'(num_chars)) begin
      slot = c - f;
    end else begin
      slot = int'(CHAR_FALLBACK) - f;
    end
    return glyph_adv[slot % GLYPH_SLOTS];
  endfunction

  function automatic longint gap_to(longint w);
    longint d;
    d = target_x - w;
    return (d < 0) ? -d : d;
  endfunction

  function automatic void clear_string();
    run_width  = 0;
    prev_width = 0;
    char_pos   = 0;
    caret_set  = 1'b0;
    caret_at   = 0;
  endfunction

  task automatic measure_char(in_req_t r);
    longint      add;
    longint      below_edge;
    int unsigned here;
    out_res_t    res;
    if (char_pos < MAX_STRING) begin
      here = char_pos;
      if (r.char_code == CHAR_TAB) begin
        add = advance_of(CHAR_SPACE) << TAB_SHIFT;
      end else if (r.char_code == CHAR_CR ||
                   (r.char_code >= CHAR_SILENT_LO && r.char_code <= CHAR_SILENT_HI)) begin
        add = 0;
      end else begin
        add = advance_of(r.char_code);
      end
      prev_width = run_width;
      run_width  = run_width + add;
      if (run_width > WIDTH_MAX) begin
        run_width = WIDTH_MAX;
      end
      char_pos++;
      if (!caret_set && (run_width > target_x || r.is_last)) begin
        caret_set = 1'b1;
        caret_at  = (gap_to(prev_width) < gap_to(run_width)) ? here : here + 1;
      end
    end
    if (r.is_last) begin
      if (!caret_set) begin
        caret_at = (gap_to(prev_width) < gap_to(run_width)) ? char_pos - 1 : char_pos;
      end
      below_edge = line_height;
      below_edge += BELOW_MARGIN << FRAC_BITS;
      if (target_y > below_edge) begin
        caret_at = char_pos;
      end
      res.total_width = run_width[WIDTH_W-1:0];
      res.char_count  = char_pos[COUNT_W-1:0];
      res.caret_index = caret_at[COUNT_W-1:0];
      results_due.push_back(res);
      clear_string();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_res_t want;
    if (!rst_ni) begin
      first_char  = FIRST_CHAR_RST;
      num_chars   = NUM_CHARS_RST;
      line_height = LINE_HEIGHT_RST;
      target_x    = 0;
      target_y    = 0;
      clear_string();
      results_due.delete();
      mismatches  = 0;
      mismatches_o  <= 0;
      results_due_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_FIRST_CHAR:  first_char  = cfg_wdata_i[FIRST_W-1:0];
          CFG_NUM_CHARS:   num_chars   = cfg_wdata_i[NUM_W-1:0];
          CFG_LINE_HEIGHT: line_height = cfg_wdata_i[ADV_W-1:0];
          CFG_TARGET_X:    target_x    = longint'(signed'(cfg_wdata_i[TX_W-1:0]));
          CFG_TARGET_Y:    target_y    = longint'(signed'(cfg_wdata_i[TY_W-1:0]));
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        if (in_req_i.func == FUNC_LOAD) begin
          if (in_req_i.glyph_index < GLYPH_SLOTS) begin
            glyph_adv[in_req_i.glyph_index] = in_req_i.advance;
          end
        end else begin
          measure_char(in_req_i);
        end
      end

      if (out_valid_i && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $error("result with no string pending: total_width %0d char_count %0d caret_index %0d",
                 out_res_i.total_width, out_res_i.char_count, out_res_i.caret_index);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (out_res_i.total_width !== want.total_width) begin
            $error("total_width: expected %0d, got %0d", want.total_width,
                   out_res_i.total_width);
            mismatches++;
          end
          if (out_res_i.char_count !== want.char_count) begin
            $error("char_count: expected %0d, got %0d", want.char_count,
                   out_res_i.char_count);
            mismatches++;
          end
          if (out_res_i.caret_index !== want.caret_index) begin
            $error("caret_index: expected %0d, got %0d", want.caret_index,
                   out_res_i.caret_index);
            mismatches++;
          end
        end
      end

      mismatches_o  <= mismatches;
      results_due_o <= results_due.size();
    end
  end

endmodule

// ===== tb/tb_text_width_and_caret_hit_test.sv =====
module tb_text_width_and_caret_hit_test;
  import twcht_pkg::*;

  localparam int unsigned SLOTS      = 128;
  localparam int unsigned STRING_MAX = 4096;
  localparam int unsigned FRAC       = 4;
  localparam int          PHASES     = 10;
  localparam int          LONG_PHASE = 5;
  localparam int          LIMIT      = 1000000;

  localparam logic [CODE_W-1:0] CHAR_NUL = 8'h00;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  in_req_t              in_req;
  logic                 out_valid;
  logic                 out_stall;
  out_res_t             out_res;

  int unsigned mismatch_count;
  int unsigned awaiting;
  int          cycles     = 0;
  int          gap_odds   = 0;
  int          stall_odds = 0;
  int          cur_first  = FIRST_CHAR_RST;
  int          cur_num    = NUM_CHARS_RST;

  text_width_and_caret_hit_test #(
    .GLYPH_SLOTS(SLOTS),
    .MAX_STRING (STRING_MAX),
    .FRAC_BITS  (FRAC)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_res_o  (out_res)
  );

  text_width_checker #(
    .GLYPH_SLOTS(SLOTS),
    .MAX_STRING (STRING_MAX),
    .FRAC_BITS  (FRAC)
  ) u_text_width_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_res_i    (out_res),
    .mismatches_o (mismatch_count),
    .results_due_o(awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("text_width_and_caret_hit_test test failed");
      $finish;
    end
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send(in_req_t r);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic in_req_t noise_req();
    logic [31:0] bits;
    bits = $urandom;
    return bits[$bits(in_req_t)-1:0];
  endfunction

  task automatic put_char(logic [CODE_W-1:0] code, bit last);
    in_req_t r;
    r           = noise_req();
    r.func      = FUNC_MEASURE;
    r.char_code = code;
    r.is_last   = last;
    send(r);
  endtask

  task automatic put_glyph(int slot, int adv);
    in_req_t r;
    r             = noise_req();
    r.func        = FUNC_LOAD;
    r.glyph_index = GIDX_W'(slot);
    r.advance     = ADV_W'(adv);
    send(r);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(int fc, int nc, int lh, longint tx, longint ty);
    logic [CFG_IDX_W-1:0] idx [5];
    logic [CFG_DAT_W-1:0] val [5];
    idx    = '{CFG_FIRST_CHAR, CFG_NUM_CHARS, CFG_LINE_HEIGHT, CFG_TARGET_X, CFG_TARGET_Y};
    val[0] = CFG_DAT_W'(fc);
    val[1] = CFG_DAT_W'(nc);
    val[2] = CFG_DAT_W'(lh);
    val[3] = tx[TX_W-1:0];
    val[4] = CFG_DAT_W'(ty[TY_W-1:0]);
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_we    <= 1'b0;
    cur_first = fc;
    cur_num   = nc;
  endtask

  function automatic logic [CODE_W-1:0] pick_char();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return CODE_W'(cur_first + $urandom_range(0, cur_num - 1));
    end else if (roll < 65) begin
      return CHAR_TAB;
    end else if (roll < 77) begin
      case ($urandom_range(0, 2))
        0:       return CHAR_CR;
        1:       return CODE_W'($urandom_range(CHAR_SILENT_LO, CHAR_SILENT_HI));
        default: return CHAR_NUL;
      endcase
    end else if (roll < 88) begin
      return CODE_W'($urandom_range(128, 255));
    end
    return CODE_W'($urandom_range(0, 255));
  endfunction

  function automatic int pick_odds();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 3;
      default: return 12;
    endcase
  endfunction

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_FIRST_CHAR;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_req    <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_odds   = 4;
    stall_odds = 4;
    // space gets one pixel, '!' nothing, the fallback glyph the widest advance
    for (int i = 0; i < SLOTS; i++) begin
      put_glyph(i, (i == 0) ? 16 : (i == 1) ? 0 : (i == 95) ? 4095 : $urandom_range(0, 4095));
    end

    put_char(8'h41, 1'b1);
    put_char(8'h21, 1'b1);
    put_char(CHAR_NUL, 1'b0);
    put_char(CHAR_CR, 1'b0);
    put_char(CHAR_SILENT_LO, 1'b0);
    put_char(CHAR_SILENT_HI, 1'b0);
    put_char(8'h06, 1'b0);
    put_char(CHAR_TAB, 1'b0);
    put_char(8'h80, 1'b0);
    put_char(8'hFF, 1'b0);
    put_char(CHAR_FALLBACK, 1'b0);
    put_char(8'h7E, 1'b0);
    put_char(8'h1F, 1'b1);
    settle();

    // hit exactly halfway, then just on and just below the line edge
    set_regs(FIRST_CHAR_RST, NUM_CHARS_RST, LINE_HEIGHT_RST, 8, 336);
    put_char(CHAR_SPACE, 1'b0);
    put_char(CHAR_SPACE, 1'b1);
    settle();
    set_regs(FIRST_CHAR_RST, NUM_CHARS_RST, LINE_HEIGHT_RST, 8, 337);
    put_char(CHAR_SPACE, 1'b0);
    put_char(CHAR_SPACE, 1'b1);
    settle();
    set_regs(FIRST_CHAR_RST, NUM_CHARS_RST, LINE_HEIGHT_RST, 1000, 0);
    put_char(CHAR_SPACE, 1'b0);
    put_char(CHAR_SPACE, 1'b1);
    settle();
    set_regs(FIRST_CHAR_RST, NUM_CHARS_RST, LINE_HEIGHT_RST, -5, 0);
    put_char(CHAR_SPACE, 1'b1);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      int     fc;
      int     nc;
      int     lh;
      longint tx;
      longint ty;
      int     budget;
      int     len;
      gap_odds   = (p == PHASES - 1) ? 0 : pick_odds();
      stall_odds = (p == PHASES - 1) ? 0 : pick_odds();
      fc = $urandom_range(0, 127);
      nc = $urandom_range(1, 128);
      lh = $urandom_range(0, 4095);
      case ($urandom_range(0, 2))
        0:       tx = longint'($urandom_range(0, 2112)) - 64;
        1:       tx = longint'($urandom_range(0, 200000));
        default: tx = longint'($urandom_range(0, 2**27 - 1)) - 2**26;
      endcase
      if ($urandom_range(0, 3) == 0) begin
        ty = longint'($urandom_range(0, 65535)) - 32768;
      end else begin
        ty = longint'($urandom_range(0, 4400)) - 200;
      end
      case (p)
        1: begin
          fc = 0;
          nc = 128;
          tx = -(2**26);
          ty = -32768;
        end
        2: begin
          fc = 127;
          nc = 1;
          tx = 2**26 - 1;
          ty = 32767;
        end
        3: lh = 0;
        4: lh = 4095;
        LONG_PHASE: begin
          fc = FIRST_CHAR_RST;
          nc = NUM_CHARS_RST;
        end
        default: ;
      endcase
      set_regs(fc, nc, lh, tx, ty);

      repeat (16) begin
        put_glyph($urandom_range(0, 127),
                  (p % 2 == 1) ? $urandom_range(0, 15) : $urandom_range(0, 4095));
      end

      budget = 90;
      while (budget > 0) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 60) : $urandom_range(1, 10);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 11) == 0) begin
            put_glyph($urandom_range(0, 127), $urandom_range(0, 4095));
          end
          put_char(pick_char(), k == len - 1);
        end
        budget -= len;
      end
      settle();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("text_width_and_caret_hit_test test passed");
    end else begin
      $display("text_width_and_caret_hit_test test failed");
    end
    $finish;
  end

endmodule
